// ===== src/crc_bit_serial_generate_check_defines.svh =====
// Assertion macros for the checker file.
`ifndef CRC_BIT_SERIAL_GENERATE_CHECK_DEFINES_SVH
`define CRC_BIT_SERIAL_GENERATE_CHECK_DEFINES_SVH

// Check a property at every clock edge, reset included.
`define CBSG_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");

// Check a property at every clock edge outside reset.
`define CBSG_ASSERT_RUN(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`endif

// ===== src/cbsg_pkg.sv =====
// Shared constants, types and division helpers for the bit-serial CRC block.
package cbsg_pkg;

	localparam int CRC_W      = 16;
	localparam int MAX_DEGREE = 16;
	localparam int DEG_W      = 5;
	localparam int IDX_W      = 4;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;

	// Configuration register indexes
	localparam logic REG_DEGREE    = 1'b0;
	localparam logic REG_GENERATOR = 1'b1;

	typedef enum logic [1:0] {
		JOB_ECHO     = 2'd0,
		JOB_CHECK    = 2'd1,
		JOB_GEN_LAST = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t        kind;
		logic             data;
		logic [CRC_W-1:0] rem;
	} job_t;

	// Clamp the programmed degree to 1..MAX_DEGREE.
	function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] deg);
		logic [DEG_W-1:0] d;
		d = deg;
		if (d == '0) begin
			d = DEG_W'(1);
		end else if (d > DEG_W'(MAX_DEGREE)) begin
			d = DEG_W'(MAX_DEGREE);
		end
		return d;
	endfunction

	// One step of modulo-2 long division: shift a bit in, subtract on a carry-out.
	function automatic logic [CRC_W-1:0] crc_divide(input logic [CRC_W-1:0] rem,
			input logic bit_in, input logic [DEG_W-1:0] deg, input logic [CRC_W-1:0] gen);
		logic [CRC_W-1:0] mask;
		logic [DEG_W-1:0] top_idx;
		logic             top;
		logic [CRC_W-1:0] nxt;
		mask = '0;
		for (int i = 0; i < CRC_W; i++) begin
			mask[i] = (DEG_W'(i) < deg);
		end
		top_idx = deg - DEG_W'(1);
		top = rem[top_idx[IDX_W-1:0]];
		nxt = {rem[CRC_W-2:0], bit_in} & mask;
		if (top) begin
			nxt = nxt ^ (gen & mask);
		end
		return nxt;
	endfunction

endpackage

// ===== src/cbsg_front.sv =====
// Front end: divides each accepted bit into the running remainder and issues jobs.
module cbsg_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic                               action,
	input  logic                               data_bit,
	input  logic                               last_bit,
	input  logic [cbsg_pkg::DEG_W-1:0]         deg,
	input  logic [cbsg_pkg::CRC_W-1:0]         gen,
	output logic                               job_push,
	output cbsg_pkg::job_t                     job
);

	logic [cbsg_pkg::CRC_W-1:0] rem_q;
	logic [cbsg_pkg::CRC_W-1:0] rem_next;

	assign rem_next = cbsg_pkg::crc_divide(rem_q, data_bit, deg, gen);

	// Check bits that are not last produce no word.
	assign job_push = accept && (!action || last_bit);

	always_comb begin
		job.data = data_bit;
		job.rem  = rem_next;
		if (action) begin
			job.kind = cbsg_pkg::JOB_CHECK;
		end else if (last_bit) begin
			job.kind = cbsg_pkg::JOB_GEN_LAST;
		end else begin
			job.kind = cbsg_pkg::JOB_ECHO;
		end
	end

	// Clear the remainder at the end of every frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (accept) begin
			rem_q <= last_bit ? '0 : rem_next;
		end
	end

endmodule

// ===== src/cbsg_job_q.sv =====
// Short job queue between the front end and the back end.
module cbsg_job_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  cbsg_pkg::job_t wr_job,
	output logic           q_full,
	input  logic           rd_en,
	output logic           q_empty,
	output cbsg_pkg::job_t rd_job
);

	cbsg_pkg::job_t                  mem_q [cbsg_pkg::QDEPTH];
	logic [cbsg_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [cbsg_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [cbsg_pkg::QCNT_W-1:0]     cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign q_full  = (cnt_q == cbsg_pkg::QCNT_W'(cbsg_pkg::QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + cbsg_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + cbsg_pkg::QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + cbsg_pkg::QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - cbsg_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ===== src/cbsg_back.sv =====
// Back end: turns jobs into result words, including the appended-zero division.
module cbsg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cbsg_pkg::DEG_W-1:0]  deg,
	input  logic [cbsg_pkg::CRC_W-1:0]  gen,
	input  logic                        job_empty,
	input  cbsg_pkg::job_t              job,
	output logic                        job_pop,
	input  logic                        out_pop,
	output logic                        out_valid,
	output logic                        out_frame_bit,
	output logic [cbsg_pkg::CRC_W-1:0]  out_remainder,
	output logic                        out_error,
	output logic                        out_final
);

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} back_state_t;

	back_state_t                 state_q, state_d;
	logic [cbsg_pkg::DEG_W-1:0]  cnt_q, cnt_d;
	logic [cbsg_pkg::CRC_W-1:0]  rem_q, rem_d;
	logic                        valid_q;
	logic                        fb_q, err_q, fin_q;
	logic [cbsg_pkg::CRC_W-1:0]  remo_q;
	logic                        out_free;
	logic                        load;
	logic                        fb_d, err_d, fin_d;
	logic [cbsg_pkg::CRC_W-1:0]  remo_d;
	logic [cbsg_pkg::DEG_W-1:0]  bit_idx;

	assign out_free = !valid_q || out_pop;
	assign bit_idx  = cnt_q - cbsg_pkg::DEG_W'(1);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		rem_d   = rem_q;
		job_pop = 1'b0;
		load    = 1'b0;
		fb_d    = 1'b0;
		err_d   = 1'b0;
		fin_d   = 1'b0;
		remo_d  = '0;
		unique case (state_q)
			ST_RUN: begin
				if (!job_empty && out_free) begin
					job_pop = 1'b1;
					load    = 1'b1;
					unique case (job.kind)
						cbsg_pkg::JOB_ECHO: begin
							fb_d = job.data;
						end
						cbsg_pkg::JOB_CHECK: begin
							remo_d = job.rem;
							err_d  = |job.rem;
							fin_d  = 1'b1;
						end
						cbsg_pkg::JOB_GEN_LAST: begin
							fb_d    = job.data;
							rem_d   = job.rem;
							cnt_d   = deg;
							state_d = ST_DIV;
						end
						default: begin
							load = 1'b0;
						end
					endcase
				end
			end
			ST_DIV: begin
				rem_d = cbsg_pkg::crc_divide(rem_q, 1'b0, deg, gen);
				cnt_d = cnt_q - cbsg_pkg::DEG_W'(1);
				if (cnt_q == cbsg_pkg::DEG_W'(1)) begin
					cnt_d   = deg;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load  = 1'b1;
					fb_d  = rem_q[bit_idx[cbsg_pkg::IDX_W-1:0]];
					fin_d = (cnt_q == cbsg_pkg::DEG_W'(1));
					cnt_d = cnt_q - cbsg_pkg::DEG_W'(1);
					if (cnt_q == cbsg_pkg::DEG_W'(1)) begin
						state_d = ST_RUN;
					end
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		if (load) begin
			fb_q   <= fb_d;
			remo_q <= remo_d;
			err_q  <= err_d;
			fin_q  <= fin_d;
		end
	end

	assign out_valid     = valid_q;
	assign out_frame_bit = fb_q;
	assign out_remainder = remo_q;
	assign out_error     = err_q;
	assign out_final     = fin_q;

endmodule

// ===== src/crc_bit_serial_generate_check.sv =====
// Top level of the bit-serial CRC generator and checker.
//
//  channel  | handshake            | words
//  ---------+----------------------+----------------------------------------------
//  input    | push / full          | action, data_bit, last_bit
//  result   | empty / pop          | frame_bit, remainder, error, final_res
//  config   | cfg_we               | cfg_idx, cfg_wdata (0 crc_degree, 1 generator)
//
// One input word per cycle is accepted while full is low; each bit is divided into
// the remainder in the cycle it is accepted. A generate word that closes a frame
// takes the back end through d zero-division steps, then d CRC-bit words (d = degree);
// a four-deep job queue lets input keep flowing meanwhile until it fills.
// Reset clears the remainder, queue and result register; no clearing pass.
// The result register holds its word until popped; the back end stalls behind it.
module crc_bit_serial_generate_check (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        push,
	output logic                        full,
	input  logic                        action,
	input  logic                        data_bit,
	input  logic                        last_bit,
	// result channel
	output logic                        empty,
	input  logic                        pop,
	output logic                        frame_bit,
	output logic [cbsg_pkg::CRC_W-1:0]  remainder,
	output logic                        error,
	output logic                        final_res,
	// configuration port
	input  logic                        cfg_we,
	input  logic                        cfg_idx,
	input  logic [cbsg_pkg::CRC_W-1:0]  cfg_wdata
);

	logic [cbsg_pkg::DEG_W-1:0]  crc_degree_q;
	logic [cbsg_pkg::CRC_W-1:0]  generator_q;
	logic [cbsg_pkg::DEG_W-1:0]  deg;
	logic                        accept;
	logic                        job_push;
	cbsg_pkg::job_t              job_in;
	cbsg_pkg::job_t              job_out;
	logic                        job_empty;
	logic                        job_pop;
	logic                        out_valid;

	// Configuration registers; the user must write them only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_degree_q <= cbsg_pkg::DEG_W'(3);
			generator_q  <= cbsg_pkg::CRC_W'(5);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cbsg_pkg::REG_DEGREE:    crc_degree_q <= cfg_wdata[cbsg_pkg::DEG_W-1:0];
				cbsg_pkg::REG_GENERATOR: generator_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Clamp degree once for both ends.
	assign deg    = cbsg_pkg::eff_degree(crc_degree_q);
	assign accept = push && !full;

	cbsg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.action   (action),
		.data_bit (data_bit),
		.last_bit (last_bit),
		.deg      (deg),
		.gen      (generator_q),
		.job_push (job_push),
		.job      (job_in)
	);

	// Hold full while the queue is full, even for check bits that make no job.
	cbsg_job_q u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (job_in),
		.q_full  (full),
		.rd_en   (job_pop),
		.q_empty (job_empty),
		.rd_job  (job_out)
	);

	cbsg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.deg           (deg),
		.gen           (generator_q),
		.job_empty     (job_empty),
		.job           (job_out),
		.job_pop       (job_pop),
		.out_pop       (pop),
		.out_valid     (out_valid),
		.out_frame_bit (frame_bit),
		.out_remainder (remainder),
		.out_error     (error),
		.out_final     (final_res)
	);

	assign empty = !out_valid;

endmodule

// ===== src/cbsg_checker.sv =====
// Port-level checker for the bit-serial CRC block and its bind.
`include "crc_bit_serial_generate_check_defines.svh"

module cbsg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        empty,
	input logic                        pop,
	input logic                        frame_bit,
	input logic [cbsg_pkg::CRC_W-1:0]  remainder,
	input logic                        error,
	input logic                        final_res
);

	// No word is shown while reset is held.
	`CBSG_ASSERT_ALWAYS(a_empty_in_reset, clk, (!arst_n |-> empty))

	// The error flag always matches a nonzero remainder.
	`CBSG_ASSERT_RUN(a_error_matches, clk, arst_n,
		(!empty |-> (error == (remainder != '0))))

	// A nonzero remainder only ever comes on a closing check word.
	`CBSG_ASSERT_RUN(a_rem_final, clk, arst_n,
		((!empty && (remainder != '0)) |-> (final_res && !frame_bit)))

	// A stalled word holds.
	`CBSG_ASSERT_RUN(a_hold_stall, clk, arst_n,
		((!empty && !pop) |=> (!empty && $stable(remainder) && $stable(final_res))))

endmodule

bind crc_bit_serial_generate_check cbsg_checker u_cbsg_checker (.*);

// ===== sim/crc_bit_serial_generate_check_tb.sv =====
// Self-checking testbench for the bit-serial CRC generator and checker.
`timescale 1ns / 1ps

module crc_bit_serial_generate_check_tb;

	// Action codes carried on the action port
	localparam logic ACT_GENERATE = 1'b0;
	localparam logic ACT_CHECK    = 1'b1;

	// Worst back-end work after the last word: d zero steps, d CRC words, queue slack
	localparam int SETTLE_CYC = 2 * cbsg_pkg::MAX_DEGREE + 8;
	localparam int LIMIT      = 400000;
	localparam int DIR_ROWS   = 29;

	// One result word as seen on the result ports
	typedef struct packed {
		logic                       fb;
		logic [cbsg_pkg::CRC_W-1:0] rem;
		logic                       err;
		logic                       fin;
	} crc_word_t;

	// Directed rows: a plain word, a word whose check result is typed in, or a register write
	typedef enum logic [1:0] {
		ROW_WORD  = 2'd0,
		ROW_KNOWN = 2'd1,
		ROW_CFG   = 2'd2
	} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic                       act;
		logic                       dbit;
		logic                       lbit;
		logic [cbsg_pkg::CRC_W-1:0] k_rem;
		logic                       k_err;
		logic [cbsg_pkg::DEG_W-1:0] c_deg;
		logic [cbsg_pkg::CRC_W-1:0] c_gen;
	} dir_row_t;

	logic                       clk       = 1'b0;
	logic                       arst_n;
	logic                       push      = 1'b0;
	logic                       action    = 1'b0;
	logic                       data_bit  = 1'b0;
	logic                       last_bit  = 1'b0;
	logic                       pop       = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic                       cfg_idx   = 1'b0;
	logic [cbsg_pkg::CRC_W-1:0] cfg_wdata = '0;
	logic                       full;
	logic                       empty;
	logic                       frame_bit;
	logic [cbsg_pkg::CRC_W-1:0] remainder;
	logic                       error;
	logic                       final_res;

	// Predictor copy of the block's state and registers, at their reset values
	logic [cbsg_pkg::DEG_W-1:0] div_deg = cbsg_pkg::DEG_W'(3);
	logic [cbsg_pkg::CRC_W-1:0] div_gen = cbsg_pkg::CRC_W'(5);
	logic [cbsg_pkg::CRC_W-1:0] div_rem = '0;

	crc_word_t crc_due [$];
	crc_word_t want;
	int        mismatches = 0;
	int        clk_count  = 0;
	int        send_idle  = 0;
	int        recv_idle  = 0;
	int        row;
	int        sp;

	// Directed stimulus. Typed-in results are ones that follow from a few hand steps:
	// single-bit frames after reset and at degree one, a valid codeword, a frame shorter than the
	// degree. Every other row is predicted.
	dir_row_t dir_tab [DIR_ROWS] = '{
		// reset generator x^3+x^2+1: single-bit check frames
		'{ROW_KNOWN, ACT_CHECK,    1'b1, 1'b1, 16'h0001, 1'b1, 5'd0,  16'h0000},
		'{ROW_KNOWN, ACT_CHECK,    1'b0, 1'b1, 16'h0000, 1'b0, 5'd0,  16'h0000},
		// message "1" then its codeword 1101 checked back to zero
		'{ROW_WORD,  ACT_GENERATE, 1'b1, 1'b1, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_CHECK,    1'b1, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_CHECK,    1'b1, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_CHECK,    1'b0, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_KNOWN, ACT_CHECK,    1'b1, 1'b1, 16'h0000, 1'b0, 5'd0,  16'h0000},
		// mixed actions in one frame, closed once by generate and once by check
		'{ROW_WORD,  ACT_GENERATE, 1'b1, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_CHECK,    1'b0, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_GENERATE, 1'b1, 1'b1, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_GENERATE, 1'b0, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_CHECK,    1'b1, 1'b1, 16'h0000, 1'b0, 5'd0,  16'h0000},
		// degree zero runs as one; generator bits above the degree drop out
		'{ROW_CFG,   ACT_CHECK,    1'b0, 1'b0, 16'h0000, 1'b0, 5'd0,  16'hFFFF},
		'{ROW_WORD,  ACT_GENERATE, 1'b1, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_GENERATE, 1'b0, 1'b1, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_KNOWN, ACT_CHECK,    1'b1, 1'b1, 16'h0001, 1'b1, 5'd0,  16'h0000},
		// degree above the limit runs as sixteen; short frame is its own remainder
		'{ROW_CFG,   ACT_CHECK,    1'b0, 1'b0, 16'h0000, 1'b0, 5'd31, 16'hFFFF},
		'{ROW_WORD,  ACT_CHECK,    1'b1, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_CHECK,    1'b0, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_KNOWN, ACT_CHECK,    1'b1, 1'b1, 16'h0005, 1'b1, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_GENERATE, 1'b1, 1'b1, 16'h0000, 1'b0, 5'd0,  16'h0000},
		// full-width generator, then a register write in the middle of a frame
		'{ROW_CFG,   ACT_CHECK,    1'b0, 1'b0, 16'h0000, 1'b0, 5'd16, 16'h1021},
		'{ROW_WORD,  ACT_GENERATE, 1'b1, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_GENERATE, 1'b0, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_GENERATE, 1'b1, 1'b1, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_CHECK,    1'b1, 1'b0, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_CFG,   ACT_CHECK,    1'b0, 1'b0, 16'h0000, 1'b0, 5'd1,  16'h0000},
		'{ROW_WORD,  ACT_CHECK,    1'b1, 1'b1, 16'h0000, 1'b0, 5'd0,  16'h0000},
		'{ROW_WORD,  ACT_GENERATE, 1'b1, 1'b1, 16'h0000, 1'b0, 5'd0,  16'h0000}
	};

	crc_bit_serial_generate_check uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.data_bit  (data_bit),
		.last_bit  (last_bit),
		.empty     (empty),
		.pop       (pop),
		.frame_bit (frame_bit),
		.remainder (remainder),
		.error     (error),
		.final_res (final_res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Clamp the programmed degree into the range the divider supports.
	function automatic int unsigned live_degree(logic [cbsg_pkg::DEG_W-1:0] deg);
		if (deg == '0) begin
			return 1;
		end
		if (deg > cbsg_pkg::MAX_DEGREE) begin
			return cbsg_pkg::MAX_DEGREE;
		end
		return 32'(deg);
	endfunction

	// Shift one bit into the remainder; subtract the generator when a one falls off the top.
	function automatic logic [cbsg_pkg::CRC_W-1:0] mod2_shift(logic [cbsg_pkg::CRC_W-1:0] r,
			logic b, int unsigned d, logic [cbsg_pkg::CRC_W-1:0] g);
		logic [cbsg_pkg::CRC_W-1:0] m;
		logic                       carry;
		m = cbsg_pkg::CRC_W'((32'd1 << d) - 32'd1);
		carry = r[d-1];
		r = {r[cbsg_pkg::CRC_W-2:0], b} & m;
		if (carry) begin
			r = r ^ (g & m);
		end
		return r;
	endfunction

	// Divide in one accepted word and queue the result words it causes.
	task automatic divide_in_bit(logic act, logic b, logic lst);
		int unsigned                d;
		int                         i;
		logic [cbsg_pkg::CRC_W-1:0] r;
		d = live_degree(div_deg);
		r = mod2_shift(div_rem, b, d, div_gen);
		if (!lst) begin
			div_rem = r;
			if (act == ACT_GENERATE) begin
				crc_due.push_back('{b, '0, 1'b0, 1'b0});
			end
		end else begin
			if (act == ACT_GENERATE) begin
				// echo the bit, flush d zeros through, then send the CRC msb first
				crc_due.push_back('{b, '0, 1'b0, 1'b0});
				repeat (d) r = mod2_shift(r, 1'b0, d, div_gen);
				for (i = int'(d); i > 0; i--) begin
					crc_due.push_back('{r[i-1], '0, 1'b0, i == 1});
				end
			end else begin
				crc_due.push_back('{1'b0, r, r != '0, 1'b1});
			end
			div_rem = '0;
		end
	endtask

	// Offer one word, idling at random first; predict it at the edge that takes it.
	task automatic send_word(logic act, logic b, logic lst);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push     <= 1'b1;
		action   <= act;
		data_bit <= b;
		last_bit <= lst;
		do @(posedge clk); while (full);
		divide_in_bit(act, b, lst);
	endtask

	// Hold input off until every expected word is out, then let the back end settle.
	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (crc_due.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Write both registers back to back; call only with the block idle.
	task automatic write_regs(logic [cbsg_pkg::DEG_W-1:0] deg,
			logic [cbsg_pkg::CRC_W-1:0] gen);
		cfg_we    <= 1'b1;
		cfg_idx   <= cbsg_pkg::REG_DEGREE;
		cfg_wdata <= cbsg_pkg::CRC_W'(deg);
		@(posedge clk);
		cfg_idx   <= cbsg_pkg::REG_GENERATOR;
		cfg_wdata <= gen;
		@(posedge clk);
		cfg_we    <= 1'b0;
		div_deg = deg;
		div_gen = gen;
	endtask

	// Random frames until about n words are sent. Most are well formed: generate
	// messages, random check frames and valid codewords (some with one bit flipped);
	// the rest are noise with mixed actions and stray last marks.
	task automatic run_frames(int n);
		int                         sent;
		int                         kind;
		int                         len;
		int                         i;
		int                         flip;
		int unsigned                d;
		logic                       act;
		logic [cbsg_pkg::CRC_W-1:0] r;
		logic                       bits [$];
		sent = 0;
		while (sent < n) begin
			kind = int'($urandom_range(0, 9));
			len  = int'(($urandom_range(0, 4) == 0) ? $urandom_range(7, 16)
				: $urandom_range(1, 5));
			act  = (kind < 4) ? ACT_GENERATE : ACT_CHECK;
			bits.delete();
			for (i = 0; i < len; i++) begin
				bits.push_back(1'($urandom));
			end
			if (kind >= 6 && kind < 9) begin
				// append the CRC so the frame divides to zero from a fresh remainder
				d = live_degree(div_deg);
				r = '0;
				for (i = 0; i < len; i++) begin
					r = mod2_shift(r, bits[i], d, div_gen);
				end
				repeat (d) r = mod2_shift(r, 1'b0, d, div_gen);
				for (i = int'(d); i > 0; i--) begin
					bits.push_back(r[i-1]);
				end
				if ($urandom_range(0, 2) == 0) begin
					flip = int'($urandom_range(0, bits.size() - 1));
					bits[flip] = ~bits[flip];
				end
			end
			for (i = 0; i < bits.size(); i++) begin
				if (kind == 9) begin
					send_word(1'($urandom), bits[i], $urandom_range(0, 3) == 0);
				end else begin
					send_word(act, bits[i], i == bits.size() - 1);
				end
			end
			sent += bits.size();
		end
	endtask

	// Result side: check each popped word against the oldest expectation, then
	// decide whether to stall on the next edge.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (crc_due.size() == 0) begin
				$display("%0t: unexpected word fb=%0b rem=%h err=%0b fin=%0b",
					$time, frame_bit, remainder, error, final_res);
				mismatches++;
			end else begin
				want = crc_due.pop_front();
				if (frame_bit !== want.fb) begin
					$display("%0t: frame_bit expected %0b got %0b", $time, want.fb, frame_bit);
					mismatches++;
				end
				if (remainder !== want.rem) begin
					$display("%0t: remainder expected %h got %h", $time, want.rem, remainder);
					mismatches++;
				end
				if (error !== want.err) begin
					$display("%0t: error expected %0b got %0b", $time, want.err, error);
					mismatches++;
				end
				if (final_res !== want.fin) begin
					$display("%0t: final_res expected %0b got %0b", $time, want.fin, final_res);
					mismatches++;
				end
			end
		end
		pop <= ($urandom_range(99) >= recv_idle);
	end

	// Watchdog: far above the slowest legal run
	always @(posedge clk) begin
		clk_count++;
		if (clk_count > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: steady input, moderate receiver stalls
		send_idle = 0;
		recv_idle = 30;
		for (row = 0; row < DIR_ROWS; row++) begin
			if (dir_tab[row].kind == ROW_CFG) begin
				drain_results();
				write_regs(dir_tab[row].c_deg, dir_tab[row].c_gen);
			end else begin
				send_word(dir_tab[row].act, dir_tab[row].dbit, dir_tab[row].lbit);
				if (dir_tab[row].kind == ROW_KNOWN) begin
					crc_due[$] = '{1'b0, dir_tab[row].k_rem, dir_tab[row].k_err, 1'b1};
				end
			end
		end

		// Random part in six legs: sender-light/receiver-heavy idling, then the reverse,
		// then none. Each leg drains fully before its register write, so the sender
		// pauses until every expected word has come; a leg may end mid-frame, which
		// makes the write land between bits of an open frame.
		for (sp = 0; sp < 6; sp++) begin
			send_idle = (sp < 2) ? 27 : (sp < 4) ? 72 : 0;
			recv_idle = (sp < 2) ? 72 : (sp < 4) ? 27 : 0;
			drain_results();
			write_regs((sp == 0) ? 5'd16 : (sp == 3) ? 5'd1 : 5'($urandom_range(0, 31)),
				(sp == 1) ? 16'hFFFF : (sp == 4) ? 16'h0000 : 16'($urandom));
			run_frames(14);
		end

		drain_results();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/cbsg_pkg.sv
src/cbsg_front.sv
src/cbsg_job_q.sv
src/cbsg_back.sv
src/crc_bit_serial_generate_check.sv
src/cbsg_checker.sv
sim/crc_bit_serial_generate_check_tb.sv
